// ----- rtl/poly_sum_product_accumulate_top_assert.svh -----
// Assertion macros for the polynomial multiply-accumulate block.
// They expect signals named clk and arst_n in the scope of use.
`ifndef POLY_SUM_PRODUCT_ACCUMULATE_TOP_ASSERT_SVH
`define POLY_SUM_PRODUCT_ACCUMULATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSPA_ASSERT_IMP(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSPA_ASSERT_NXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- rtl/pspa_pkg.sv -----
package pspa_pkg;

	localparam int unsigned MAX_A_LEN_DEF  = 32;
	localparam int unsigned MAX_B_LEN_DEF  = 32;
	localparam int unsigned COEF_WIDTH_DEF = 32;

	localparam int unsigned IDX_W     = 6;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned FIELD_W   = 32;
	localparam int unsigned ACC_DEPTH = 64;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_A_LENGTH = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_B_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		MODE_ADDEND  = 2'd0,
		MODE_MULT    = 2'd1,
		MODE_ACC     = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_LD,
		ST_TERM_RD,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_WB
	} state_t;

	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          index;
		logic signed [FIELD_W-1:0] first_value;
		logic signed [FIELD_W-1:0] second_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]          result_index;
		logic signed [FIELD_W-1:0] coefficient;
		logic                      last;
	} out_item_t;

	typedef struct packed {
		logic             asum_we;
		logic             mult_we;
		logic             acc_load_we;
		logic             acc_init;
		logic             mul_start;
		logic             acc_add;
		logic             wb;
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] m;
		logic             last;
	} ctrl_t;

	typedef struct packed {
		logic mul_done;
		logic out_busy;
	} status_t;

endpackage

// ----- rtl/pspa_mul.sv -----
module pspa_mul #(
	parameter int unsigned COEF_WIDTH = pspa_pkg::COEF_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COEF_WIDTH-1:0] op_a,
	input  logic [COEF_WIDTH-1:0] op_b,
	output logic                  done,
	output logic [COEF_WIDTH-1:0] product
);
	import pspa_pkg::*;

	// Number of 32 by 32 partial products needed for the low COEF_WIDTH bits.
	localparam int unsigned NPROD = (COEF_WIDTH > 32) ? 3 : 1;
	localparam int unsigned CNT_W = 2;

	logic [COEF_WIDTH-1:0] a_q, b_q, sum_q, term, sum_nxt;
	logic [63:0]           a_ext, b_ext, part_s1;
	logic [31:0]           x, y;
	logic                  hi_s1;
	logic                  busy_q, done_q;
	logic [CNT_W-1:0]      cnt_q;

	assign a_ext = 64'(a_q);
	assign b_ext = 64'(b_q);

	always_comb begin
		case (cnt_q)
			2'd0: begin
				x = a_ext[31:0];
				y = b_ext[31:0];
			end
			2'd1: begin
				x = a_ext[31:0];
				y = b_ext[63:32];
			end
			default: begin
				x = a_ext[63:32];
				y = b_ext[31:0];
			end
		endcase
	end

	assign term    = hi_s1 ? COEF_WIDTH'(part_s1 << 32) : COEF_WIDTH'(part_s1);
	assign sum_nxt = sum_q + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(NPROD));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NPROD)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			sum_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < CNT_W'(NPROD)) begin
				part_s1 <= 64'(x) * 64'(y);
				hi_s1   <= (cnt_q != '0);
			end
			if (cnt_q != '0) begin
				sum_q <= sum_nxt;
			end
		end
	end

	assign done    = done_q;
	assign product = sum_q;

endmodule

// ----- rtl/pspa_dp.sv -----
module pspa_dp #(
	parameter int unsigned MAX_A_LEN  = pspa_pkg::MAX_A_LEN_DEF,
	parameter int unsigned MAX_B_LEN  = pspa_pkg::MAX_B_LEN_DEF,
	parameter int unsigned COEF_WIDTH = pspa_pkg::COEF_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pspa_pkg::in_item_t  item,
	input  pspa_pkg::ctrl_t     ctrl,
	output pspa_pkg::status_t   status,
	output logic                result_valid,
	input  logic                result_stall,
	output pspa_pkg::out_item_t result
);
	import pspa_pkg::*;

	localparam int unsigned A_AW = (MAX_A_LEN > 1) ? $clog2(MAX_A_LEN) : 1;
	localparam int unsigned B_AW = (MAX_B_LEN > 1) ? $clog2(MAX_B_LEN) : 1;

	// The addend store keeps the sum of the two addends, the only form used.
	logic [COEF_WIDTH-1:0] asum_mem [MAX_A_LEN];
	logic [COEF_WIDTH-1:0] mult_mem [MAX_B_LEN];
	logic [COEF_WIDTH-1:0] acc_mem  [ACC_DEPTH];

	logic [COEF_WIDTH-1:0] first_w, second_w;
	logic [COEF_WIDTH-1:0] asum_rd_q, mult_rd_q, acc_rd_q, acc_q;
	logic [COEF_WIDTH-1:0] acc_wdata, product;
	logic [IDX_W-1:0]      acc_waddr, bidx;
	logic                  acc_we, mul_done;
	logic                  result_valid_q;
	out_item_t             result_q;

	assign first_w  = COEF_WIDTH'($signed(item.first_value));
	assign second_w = COEF_WIDTH'($signed(item.second_value));
	assign bidx     = ctrl.n - ctrl.m;

	assign acc_we    = ctrl.acc_load_we || ctrl.wb;
	assign acc_waddr = ctrl.wb ? ctrl.n : item.index;
	assign acc_wdata = ctrl.wb ? acc_q : first_w;

	always_ff @(posedge clk) begin
		if (ctrl.asum_we) begin
			asum_mem[item.index[A_AW-1:0]] <= first_w + second_w;
		end
		asum_rd_q <= asum_mem[ctrl.m[A_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctrl.mult_we) begin
			mult_mem[item.index[B_AW-1:0]] <= first_w;
		end
		mult_rd_q <= mult_mem[bidx[B_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[ctrl.n];
	end

	pspa_mul #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mul_start),
		.op_a    (asum_rd_q),
		.op_b    (mult_rd_q),
		.done    (mul_done),
		.product (product)
	);

	always_ff @(posedge clk) begin
		if (ctrl.acc_init) begin
			acc_q <= acc_rd_q;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + product;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.wb) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wb) begin
			result_q.result_index <= ctrl.n;
			result_q.coefficient  <= FIELD_W'(acc_q);
			result_q.last         <= ctrl.last;
		end
	end

	assign status.mul_done = mul_done;
	assign status.out_busy = result_valid_q && result_stall;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

endmodule

// ----- rtl/pspa_seq.sv -----
module pspa_seq #(
	parameter int unsigned MAX_A_LEN = pspa_pkg::MAX_A_LEN_DEF,
	parameter int unsigned MAX_B_LEN = pspa_pkg::MAX_B_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  pspa_pkg::in_item_t            item,
	input  logic [pspa_pkg::LEN_W-1:0]    a_length,
	input  logic [pspa_pkg::LEN_W-1:0]    b_length,
	input  pspa_pkg::status_t             status,
	output pspa_pkg::ctrl_t               ctrl
);
	import pspa_pkg::*;

	state_t           state_q, state_nxt;
	logic [LEN_W-1:0] na_q, nb_q, na_clamp, nb_clamp;
	logic [IDX_W-1:0] n_q, m_q, hi_q, top, lo, hi, n_inc;
	logic             accept, last;

	assign accept = item_valid && (state_q == ST_IDLE);

	assign na_clamp = (a_length == '0) ? LEN_W'(1) :
		((a_length > LEN_W'(MAX_A_LEN)) ? LEN_W'(MAX_A_LEN) : a_length);
	assign nb_clamp = (b_length == '0) ? LEN_W'(1) :
		((b_length > LEN_W'(MAX_B_LEN)) ? LEN_W'(MAX_B_LEN) : b_length);

	assign top   = na_q + nb_q - IDX_W'(2);
	assign last  = (n_q == top);
	assign n_inc = n_q + 1'b1;
	assign lo    = (n_inc > nb_q) ? (n_inc - nb_q) : '0;
	assign hi    = (n_q < na_q - 1'b1) ? n_q : (na_q - 1'b1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.mode == MODE_COMPUTE)) begin
					state_nxt = ST_ACC_RD;
				end
			end
			ST_ACC_RD:  state_nxt = ST_ACC_LD;
			ST_ACC_LD:  state_nxt = ST_TERM_RD;
			ST_TERM_RD: state_nxt = ST_MUL_GO;
			ST_MUL_GO:  state_nxt = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (status.mul_done) begin
					state_nxt = (m_q == hi_q) ? ST_WB : ST_TERM_RD;
				end
			end
			ST_WB: begin
				if (!status.out_busy) begin
					state_nxt = last ? ST_IDLE : ST_ACC_RD;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.n    = n_q;
		ctrl.m    = m_q;
		ctrl.last = last;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_ADDEND: ctrl.asum_we = (item.index < IDX_W'(MAX_A_LEN));
						MODE_MULT:   ctrl.mult_we = (item.index < IDX_W'(MAX_B_LEN));
						MODE_ACC:    ctrl.acc_load_we = 1'b1;
						default:     ctrl.asum_we = 1'b0;
					endcase
				end
			end
			ST_ACC_LD:   ctrl.acc_init  = 1'b1;
			ST_MUL_GO:   ctrl.mul_start = 1'b1;
			ST_MUL_WAIT: ctrl.acc_add   = status.mul_done;
			ST_WB:       ctrl.wb        = !status.out_busy;
			default:     ctrl.acc_init  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			na_q    <= LEN_W'(1);
			nb_q    <= LEN_W'(1);
			n_q     <= '0;
			m_q     <= '0;
			hi_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && (item.mode == MODE_COMPUTE)) begin
				na_q <= na_clamp;
				nb_q <= nb_clamp;
				n_q  <= '0;
			end
			if (state_q == ST_ACC_RD) begin
				m_q  <= lo;
				hi_q <= hi;
			end
			if ((state_q == ST_MUL_WAIT) && status.mul_done && (m_q != hi_q)) begin
				m_q <= m_q + 1'b1;
			end
			if ((state_q == ST_WB) && !status.out_busy && !last) begin
				n_q <= n_inc;
			end
		end
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

// ----- rtl/poly_sum_product_accumulate_top.sv -----
// Polynomial sum-product multiply-accumulate: P[n] += sum of (A0[m]+A1[m])*B[n-m].
// Input channel (item_valid, item_stall, item): each transaction either loads
// one coefficient into the addend, multiplier or accumulator store, or starts a
// compute run. A load leaves the block idle, so it is ready again at once.
// A compute run walks every product term with one shared multiplier and emits
// the updated accumulator coefficients 0 to a_length+b_length-2 in index order
// on the output channel (result_valid, result_stall, result), the final one with
// last set. It walks a_length*b_length product terms in all; item_stall is high
// throughout. A single output register holds each result; while the
// receiver stalls, the sequencer waits before writing the next coefficient,
// losing nothing. The user must set the lengths through the APB port only while
// the block is idle; the block itself does not enforce this. Reset sets both
// lengths to 1 and returns the sequencer to idle; the stores are not cleared
// and must be loaded before they are read.
`include "poly_sum_product_accumulate_top_assert.svh"

module poly_sum_product_accumulate_top #(
	parameter int unsigned MAX_A_LEN  = pspa_pkg::MAX_A_LEN_DEF,
	parameter int unsigned MAX_B_LEN  = pspa_pkg::MAX_B_LEN_DEF,
	parameter int unsigned COEF_WIDTH = pspa_pkg::COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  pspa_pkg::in_item_t             item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output pspa_pkg::out_item_t            result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pspa_pkg::PADDR_W-1:0]   paddr,
	input  logic [pspa_pkg::PDATA_W-1:0]   pwdata,
	output logic [pspa_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import pspa_pkg::*;

	logic [LEN_W-1:0]     a_length_q, b_length_q;
	logic [REG_IDX_W-1:0] reg_sel;
	logic                 cfg_write;
	ctrl_t                ctrl;
	status_t              status;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_length_q <= LEN_W'(1);
			b_length_q <= LEN_W'(1);
		end else if (cfg_write) begin
			if (reg_sel == REG_A_LENGTH) begin
				a_length_q <= pwdata[LEN_W-1:0];
			end else begin
				b_length_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_B_LENGTH) ? PDATA_W'(b_length_q) : PDATA_W'(a_length_q);

	pspa_seq #(
		.MAX_A_LEN(MAX_A_LEN),
		.MAX_B_LEN(MAX_B_LEN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.a_length   (a_length_q),
		.b_length   (b_length_q),
		.status     (status),
		.ctrl       (ctrl)
	);

	pspa_dp #(
		.MAX_A_LEN (MAX_A_LEN),
		.MAX_B_LEN (MAX_B_LEN),
		.COEF_WIDTH(COEF_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ctrl         (ctrl),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`PSPA_ASSERT_NXT(a_compute_holds, item_valid && !item_stall && item.mode == MODE_COMPUTE, item_stall, "A compute transaction did not occupy the sequencer.")
	`PSPA_ASSERT_NXT(a_load_one_cycle, item_valid && !item_stall && item.mode != MODE_COMPUTE, !item_stall, "A load transaction took more than one cycle.")
	`PSPA_ASSERT_IMP(a_mul_in_run, status.mul_done, item_stall, "The multiplier finished outside a compute run.")

endmodule

// ----- test/poly_sum_product_accumulate_checker.sv -----
module poly_sum_product_accumulate_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  pspa_pkg::in_item_t             item,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  pspa_pkg::out_item_t            result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [pspa_pkg::PADDR_W-1:0]   paddr,
	input  logic [pspa_pkg::PDATA_W-1:0]   pwdata,
	output int                             mismatch_count,
	output int                             coefs_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import pspa_pkg::*;

	logic [FIELD_W-1:0] addend0_coef [MAX_A_LEN_DEF];
	logic [FIELD_W-1:0] addend1_coef [MAX_A_LEN_DEF];
	logic [FIELD_W-1:0] mult_coef [MAX_B_LEN_DEF];
	logic [FIELD_W-1:0] acc_coef [ACC_DEPTH];
	logic [LEN_W-1:0] a_len_reg = 1;
	logic [LEN_W-1:0] b_len_reg = 1;
	out_item_t pending_coefs [$];
	int mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		int na;
		int nb;
		int top_n;
		int lo;
		int hi;
		logic [FIELD_W-1:0] asum;
		logic [FIELD_W-1:0] sum;
		out_item_t want;
		if (!arst_n) begin
			a_len_reg = 1;
			b_len_reg = 1;
			pending_coefs.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_A_LENGTH: a_len_reg = pwdata[LEN_W-1:0];
					REG_B_LENGTH: b_len_reg = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end

			if (result_valid && !result_stall) begin
				if (pending_coefs.size() == 0) begin
					$error("unexpected result transaction: result_index %0d coefficient %0d last %0b",
						result.result_index, result.coefficient, result.last);
					mismatches++;
				end else begin
					want = pending_coefs.pop_front();
					if (result.result_index !== want.result_index) begin
						$error("result_index: expected %0d, got %0d",
							want.result_index, result.result_index);
						mismatches++;
					end
					if (result.coefficient !== want.coefficient) begin
						$error("coefficient: expected %0d, got %0d",
							want.coefficient, result.coefficient);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						mismatches++;
					end
				end
			end

			if (item_valid && !item_stall) begin
				case (item.mode)
					MODE_ADDEND: begin
						if (item.index < MAX_A_LEN_DEF) begin
							addend0_coef[item.index] = item.first_value;
							addend1_coef[item.index] = item.second_value;
						end
					end
					MODE_MULT: begin
						if (item.index < MAX_B_LEN_DEF)
							mult_coef[item.index] = item.first_value;
					end
					MODE_ACC: acc_coef[item.index] = item.first_value;
					MODE_COMPUTE: begin
						na = (a_len_reg == 0) ? 1 :
							((a_len_reg > MAX_A_LEN_DEF) ? MAX_A_LEN_DEF : a_len_reg);
						nb = (b_len_reg == 0) ? 1 :
							((b_len_reg > MAX_B_LEN_DEF) ? MAX_B_LEN_DEF : b_len_reg);
						top_n = na + nb - 2;
						for (int n = 0; n <= top_n; n++) begin
							lo = (n + 1 > nb) ? n + 1 - nb : 0;
							hi = (n < na - 1) ? n : na - 1;
							sum = '0;
							for (int m = lo; m <= hi; m++) begin
								asum = addend0_coef[m] + addend1_coef[m];
								sum = sum + asum * mult_coef[n - m];
							end
							acc_coef[n] = acc_coef[n] + sum;
							want.result_index = IDX_W'(n);
							want.coefficient = acc_coef[n];
							want.last = (n == top_n);
							pending_coefs.push_back(want);
						end
					end
					default: ;
				endcase
			end
		end
		mismatch_count <= mismatches;
		coefs_owed <= pending_coefs.size();
	end

endmodule

// ----- test/tb_poly_sum_product_accumulate_top.sv -----
module tb_poly_sum_product_accumulate_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pspa_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;
	localparam int ITEM_TARGET = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int mismatch_count;
	int coefs_owed;
	int items_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	bit a_loaded [MAX_A_LEN_DEF];
	bit b_loaded [MAX_B_LEN_DEF];
	bit p_loaded [ACC_DEPTH];

	int hold_left = 0;
	int stall_left = 0;
	int calm_left = 0;
	bit hold_done = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	poly_sum_product_accumulate_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	poly_sum_product_accumulate_checker coef_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.coefs_owed     (coefs_owed)
	);

	// Once in the run the receiver holds off for a long stretch while the sender
	// is offering a transaction, so that the output register fills and the input stalls.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && items_sent >= 40 && result_valid && item_valid) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (calm_left != 0) begin
			calm_left <= calm_left - 1;
			result_stall <= 1'b0;
		end else if (r < 20) begin
			calm_left <= $urandom_range(20, 120);
			result_stall <= 1'b0;
		end else if (r < 60) begin
			result_stall <= 1'b0;
		end else if (r < 92) begin
			stall_left <= $urandom_range(0, 2);
			result_stall <= 1'b1;
		end else begin
			stall_left <= $urandom_range(10, 40);
			result_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
			(psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [FIELD_W-1:0] rand_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 32'h8000_0000;
		if (r < 20) return 32'h7fff_ffff;
		if (r < 25) return 32'hffff_ffff;
		if (r < 30) return 32'h0;
		return $urandom();
	endfunction

	function automatic in_item_t make_item(input mode_t md, input int idx,
		input logic [FIELD_W-1:0] v0, input logic [FIELD_W-1:0] v1);
		in_item_t it;
		it.mode = md;
		it.index = idx[IDX_W-1:0];
		it.first_value = v0;
		it.second_value = v1;
		return it;
	endfunction

	function automatic in_item_t load_item(input mode_t md, input int idx);
		return make_item(md, idx, rand_coef(), rand_coef());
	endfunction

	function automatic int eff_len(input int raw, input int max_len);
		int v;
		v = raw & 6'h3f;
		if (v == 0) return 1;
		return (v > max_len) ? max_len : v;
	endfunction

	task automatic send_item(input in_item_t it);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) gap = 0;
		else if (r < 90) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 30);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		case (it.mode)
			MODE_ADDEND: begin
				if (it.index < MAX_A_LEN_DEF) begin
					a_loaded[it.index] = 1'b1;
					items_sent++;
				end
			end
			MODE_MULT: begin
				if (it.index < MAX_B_LEN_DEF) begin
					b_loaded[it.index] = 1'b1;
					items_sent++;
				end
			end
			MODE_ACC: begin
				p_loaded[it.index] = 1'b1;
				items_sent++;
			end
			default: items_sent++;
		endcase
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (coefs_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [REG_IDX_W-1:0] sel, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= ($urandom() & 32'hffff_ffc0) | value[LEN_W-1:0];
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic run_phase(input int a_raw, input int b_raw, input int computes);
		int na;
		int nb;
		int idx;
		mode_t md;
		settle();
		write_length(REG_A_LENGTH, a_raw);
		write_length(REG_B_LENGTH, b_raw);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		na = eff_len(a_raw, MAX_A_LEN_DEF);
		nb = eff_len(b_raw, MAX_B_LEN_DEF);
		no_gaps = ($urandom_range(0, 3) == 0);
		repeat (computes) begin
			repeat ($urandom_range(0, 6)) begin
				md = mode_t'($urandom_range(0, 2));
				if ($urandom_range(0, 99) < 15) begin
					idx = $urandom_range(0, 63);
				end else begin
					case (md)
						MODE_ADDEND: idx = $urandom_range(0, na - 1);
						MODE_MULT: idx = $urandom_range(0, nb - 1);
						default: idx = $urandom_range(0, na + nb - 2);
					endcase
				end
				send_item(load_item(md, idx));
			end
			// Every coefficient that the run will read must have been loaded first.
			for (int m = 0; m < na; m++)
				if (!a_loaded[m]) send_item(load_item(MODE_ADDEND, m));
			for (int m = 0; m < nb; m++)
				if (!b_loaded[m]) send_item(load_item(MODE_MULT, m));
			for (int n = 0; n <= na + nb - 2; n++)
				if (!p_loaded[n]) send_item(load_item(MODE_ACC, n));
			send_item(make_item(MODE_COMPUTE, $urandom_range(0, 63), $urandom(), $urandom()));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both lengths are at their reset value of one here.
		send_item(make_item(MODE_ADDEND, 0, 32'h7fff_ffff, 32'h7fff_ffff));
		send_item(make_item(MODE_MULT, 0, 32'h7fff_ffff, $urandom()));
		send_item(make_item(MODE_ACC, 0, 32'h8000_0000, $urandom()));
		send_item(make_item(MODE_COMPUTE, 63, $urandom(), $urandom()));
		send_item(make_item(MODE_ADDEND, 32, 32'h0, 32'h0));
		send_item(make_item(MODE_ADDEND, 63, 32'hffff_ffff, 32'hffff_ffff));
		send_item(make_item(MODE_MULT, 32, 32'hffff_ffff, 32'h0));
		send_item(make_item(MODE_MULT, 63, 32'h8000_0000, 32'hffff_ffff));
		send_item(make_item(MODE_ACC, 63, 32'hffff_ffff, 32'h0));
		send_item(make_item(MODE_ADDEND, 31, 32'h8000_0000, 32'h8000_0000));
		send_item(make_item(MODE_MULT, 31, 32'h8000_0000, 32'h7fff_ffff));
		send_item(make_item(MODE_ACC, 0, 32'h7fff_ffff, 32'h8000_0000));
		send_item(make_item(MODE_ADDEND, 0, 32'hffff_ffff, 32'h1));
		send_item(make_item(MODE_COMPUTE, 0, 32'h0, 32'h0));
		send_item(make_item(MODE_ADDEND, 0, 32'h8000_0000, 32'h7fff_ffff));
		send_item(make_item(MODE_MULT, 0, 32'hffff_ffff, 32'h0));
		send_item(make_item(MODE_COMPUTE, 42, 32'hffff_ffff, 32'hffff_ffff));

		run_phase(32, 32, 1);
		run_phase(0, 0, 3);
		run_phase(63, 40, 1);
		run_phase(1, 32, 2);
		run_phase(32, 1, 2);
		run_phase(33, 5, 2);
		run_phase(5, 0, 3);
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				run_phase($urandom_range(0, 63), $urandom_range(0, 63), 1);
			else
				run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(2, 6));
		end
		settle();

		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pspa_pkg.sv
rtl/pspa_mul.sv
rtl/pspa_dp.sv
rtl/pspa_seq.sv
rtl/poly_sum_product_accumulate_top.sv
test/poly_sum_product_accumulate_checker.sv
test/tb_poly_sum_product_accumulate_top.sv
